FILE: design/lbrc_pkg.sv
// ----------------------------------------------------------------------------
// lbrc_pkg
// Types and constants shared by the LDAP bind response checker modules.
// ----------------------------------------------------------------------------
package lbrc_pkg;

  // Default width of the BER length accumulators.
  localparam int unsigned LENGTH_WIDTH_DEF = 32;

  localparam logic [7:0] TAG_MESSAGE   = 8'h30;
  localparam logic [7:0] TAG_BIND_RESP = 8'h61;
  localparam logic [7:0] TAG_INTEGER   = 8'h02;
  localparam logic [7:0] TAG_ENUM      = 8'h0A;
  localparam logic [7:0] BYTE_ONE      = 8'h01;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam int unsigned MIN_MSG_LEN  = 8;
  localparam int unsigned MIN_BIND_LEN = 3;

  typedef enum logic [2:0] {
    REQ_DATA      = 3'd0,
    REQ_CONNECTED = 3'd1,
    REQ_TIMEOUT   = 3'd2,
    REQ_ERROR     = 3'd3,
    REQ_CLOSED    = 3'd4,
    REQ_SHUTDOWN  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_WORKING = 2'd0,
    ST_FAILED  = 2'd1,
    ST_OK      = 2'd2
  } status_e;

  // Failure reasons; R_SUCCESS only appears as a pending body outcome.
  typedef enum logic [3:0] {
    R_NONE        = 4'd0,
    R_BAD_TYPE    = 4'd1,
    R_SHORT_MSG   = 4'd2,
    R_BAD_ID      = 4'd3,
    R_BAD_RESP    = 4'd4,
    R_SHORT_BIND  = 4'd5,
    R_BAD_RES_TAG = 4'd6,
    R_REFUSED     = 4'd7,
    R_TIMEOUT     = 4'd8,
    R_ERROR       = 4'd9,
    R_CLOSED      = 4'd10,
    R_SUCCESS     = 4'd11
  } reason_e;

  typedef enum logic [3:0] {
    PH_TAG   = 4'd0,
    PH_LEN1  = 4'd1,
    PH_LENX  = 4'd2,
    PH_ID0   = 4'd3,
    PH_ID1   = 4'd4,
    PH_ID2   = 4'd5,
    PH_RTAG  = 4'd6,
    PH_BLEN1 = 4'd7,
    PH_BLENX = 4'd8,
    PH_RC0   = 4'd9,
    PH_RC1   = 4'd10,
    PH_RC2   = 4'd11,
    PH_TAIL  = 4'd12
  } phase_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] fail_reason;
    logic [7:0] server_result;
    logic       decided;
    logic       send_bind;
  } result_t;

endpackage

FILE: design/lbrc_if.sv
// ----------------------------------------------------------------------------
// lbrc_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface lbrc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface lbrc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] fail_reason;
  logic [7:0] server_result;
  logic       decided;
  logic       send_bind;

  modport source (output valid, output status, output fail_reason, output server_result,
                  output decided, output send_bind, input ready);
  modport sink   (input valid, input status, input fail_reason, input server_result,
                  input decided, input send_bind, output ready);
endinterface

FILE: design/lbrc_parser.sv
// ----------------------------------------------------------------------------
// lbrc_parser
// BER parse state and bind verdict; one item is applied per accepted cycle.
// ----------------------------------------------------------------------------
module lbrc_parser #(
  parameter int unsigned LengthWidth = lbrc_pkg::LENGTH_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  lbrc_pkg::item_t   item_i,
  output lbrc_pkg::result_t result_o
);
  import lbrc_pkg::*;

  localparam logic [LengthWidth-1:0] LenOnes    = '1;
  localparam logic [LengthWidth-1:0] MinMsgLen  = LengthWidth'(MIN_MSG_LEN);
  localparam logic [LengthWidth-1:0] MinBindLen = LengthWidth'(MIN_BIND_LEN);

  phase_e                 phase_q,   phase_d;
  status_e                verdict_q, verdict_d;
  reason_e                reason_q,  reason_d;
  reason_e                pend_q,    pend_d;
  logic [LengthWidth-1:0] msg_len_q, msg_len_d;
  logic [LengthWidth-1:0] bind_len_q, bind_len_d;
  logic [LengthWidth-1:0] body_cnt_q, body_cnt_d;
  logic [6:0]             len_left_q, len_left_d;
  logic [7:0]             result_q,  result_d;

  logic       was_working;
  logic       bind_req;
  logic       hdr_done;
  logic       blen_done;
  logic [7:0] b;

  always_comb begin
    phase_d    = phase_q;
    verdict_d  = verdict_q;
    reason_d   = reason_q;
    pend_d     = pend_q;
    msg_len_d  = msg_len_q;
    bind_len_d = bind_len_q;
    body_cnt_d = body_cnt_q;
    len_left_d = len_left_q;
    result_d   = result_q;
    bind_req   = 1'b0;
    hdr_done   = 1'b0;
    blen_done  = 1'b0;
    b          = item_i.data_byte;
    was_working = (verdict_q == ST_WORKING);

    if (was_working) begin
      case (req_e'(item_i.req_type))
        REQ_DATA: begin
          if (phase_q == PH_TAG || phase_q == PH_LEN1 || phase_q == PH_LENX) begin
            // Message header: tag and BER length.
            case (phase_q)
              PH_TAG: begin
                if (b != TAG_MESSAGE) pend_d = R_BAD_TYPE;
                phase_d = PH_LEN1;
              end
              PH_LEN1: begin
                if (!b[7]) begin
                  msg_len_d = LengthWidth'(b);
                  hdr_done  = 1'b1;
                end else begin
                  msg_len_d  = '0;
                  len_left_d = b[6:0];
                  if (b[6:0] == 7'd0) hdr_done = 1'b1;
                  else                phase_d  = PH_LENX;
                end
              end
              default: begin
                msg_len_d  = {msg_len_q[LengthWidth-9:0], b};
                len_left_d = len_left_q - 7'd1;
                if (len_left_d == 7'd0) hdr_done = 1'b1;
              end
            endcase
            if (hdr_done) begin
              if (pend_q == R_BAD_TYPE) begin
                verdict_d = ST_FAILED;
                reason_d  = R_BAD_TYPE;
              end else if (msg_len_d < MinMsgLen) begin
                verdict_d = ST_FAILED;
                reason_d  = R_SHORT_MSG;
              end else begin
                phase_d    = PH_ID0;
                body_cnt_d = '0;
              end
            end
          end else begin
            // Message body: count every byte, check the fixed fields in order.
            if (body_cnt_q != LenOnes) body_cnt_d = body_cnt_q + LengthWidth'(1);
            case (phase_q)
              PH_ID0: begin
                if (b != TAG_INTEGER) begin pend_d = R_BAD_ID; phase_d = PH_TAIL; end
                else phase_d = PH_ID1;
              end
              PH_ID1: begin
                if (b != BYTE_ONE) begin pend_d = R_BAD_ID; phase_d = PH_TAIL; end
                else phase_d = PH_ID2;
              end
              PH_ID2: begin
                if (b != BYTE_ONE) begin pend_d = R_BAD_ID; phase_d = PH_TAIL; end
                else phase_d = PH_RTAG;
              end
              PH_RTAG: begin
                if (b != TAG_BIND_RESP) begin pend_d = R_BAD_RESP; phase_d = PH_TAIL; end
                else phase_d = PH_BLEN1;
              end
              PH_BLEN1: begin
                if (!b[7]) begin
                  bind_len_d = LengthWidth'(b);
                  blen_done  = 1'b1;
                end else begin
                  bind_len_d = '0;
                  len_left_d = b[6:0];
                  if (b[6:0] == 7'd0) blen_done = 1'b1;
                  else                phase_d   = PH_BLENX;
                end
              end
              PH_BLENX: begin
                bind_len_d = {bind_len_q[LengthWidth-9:0], b};
                len_left_d = len_left_q - 7'd1;
                if (len_left_d == 7'd0) blen_done = 1'b1;
              end
              PH_RC0: begin
                if (b != TAG_ENUM) begin pend_d = R_BAD_RES_TAG; phase_d = PH_TAIL; end
                else phase_d = PH_RC1;
              end
              PH_RC1: begin
                if (b != BYTE_ONE) begin pend_d = R_BAD_RES_TAG; phase_d = PH_TAIL; end
                else phase_d = PH_RC2;
              end
              PH_RC2: begin
                result_d = b;
                pend_d   = (b != BYTE_ZERO) ? R_REFUSED : R_SUCCESS;
                phase_d  = PH_TAIL;
              end
              default: ;
            endcase
            if (blen_done) begin
              if (bind_len_d < MinBindLen) begin
                pend_d  = R_SHORT_BIND;
                phase_d = PH_TAIL;
              end else begin
                phase_d = PH_RC0;
              end
            end
            // The outcome shows once the stated length has arrived.
            if (pend_d != R_NONE && body_cnt_d >= msg_len_q) begin
              if (pend_d == R_SUCCESS) begin
                verdict_d = ST_OK;
              end else begin
                verdict_d = ST_FAILED;
                reason_d  = pend_d;
              end
            end
          end
        end
        REQ_CONNECTED: bind_req = 1'b1;
        REQ_TIMEOUT: begin verdict_d = ST_FAILED; reason_d = R_TIMEOUT; end
        REQ_ERROR:   begin verdict_d = ST_FAILED; reason_d = R_ERROR;   end
        REQ_CLOSED:  begin verdict_d = ST_FAILED; reason_d = R_CLOSED;  end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.status        = verdict_d;
    result_o.fail_reason   = reason_d;
    result_o.server_result = result_d;
    result_o.decided       = was_working && (verdict_d != ST_WORKING);
    result_o.send_bind     = bind_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TAG;
      verdict_q  <= ST_WORKING;
      reason_q   <= R_NONE;
      pend_q     <= R_NONE;
      msg_len_q  <= '0;
      bind_len_q <= '0;
      body_cnt_q <= '0;
      len_left_q <= '0;
      result_q   <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      verdict_q  <= verdict_d;
      reason_q   <= reason_d;
      pend_q     <= pend_d;
      msg_len_q  <= msg_len_d;
      bind_len_q <= bind_len_d;
      body_cnt_q <= body_cnt_d;
      len_left_q <= len_left_d;
      result_q   <= result_d;
    end
  end

  // Once decided, the verdict and reason never change again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_q != ST_WORKING) |=> (verdict_q == $past(verdict_q)) &&
                                  (reason_q == $past(reason_q)))
    else $error("verdict changed after a decision");

  // A decided result always carries a final status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.decided |-> (result_o.status != ST_WORKING))
    else $error("decided flagged with a working status");

  // The result code byte always leaves a refused or success outcome pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && was_working && phase_q == PH_RC2 && item_i.req_type == REQ_DATA)
      |=> (pend_q == R_REFUSED || pend_q == R_SUCCESS))
    else $error("result code byte left no pending outcome");

endmodule

FILE: design/lbrc_out_stage.sv
// ----------------------------------------------------------------------------
// lbrc_out_stage
// Result register with a skid entry, so that ready towards the input is
// a registered signal.
// ----------------------------------------------------------------------------
module lbrc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lbrc_pkg::result_t push_data_i,
  output logic              push_ready_o,
  output logic              out_valid_o,
  output lbrc_pkg::result_t out_data_o,
  input  logic              out_ready_i
);
  import lbrc_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q,  out_data_d;
  result_t skid_data_q, skid_data_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;

  // The skid entry is only ever occupied behind a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds data while the result register is empty");

  // A transaction arriving behind a stalled result lands in the skid entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("stalled push did not reach the skid entry");

  // A drained result register takes the skid entry next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q &&
                                       out_data_q == $past(skid_data_q)))
    else $error("skid entry not moved on drain");

endmodule

FILE: design/ldap_bind_response_checker_top.sv
// ----------------------------------------------------------------------------
// ldap_bind_response_checker_top
// Checks an LDAP bind response byte stream and connection events.
// ----------------------------------------------------------------------------
// Each input transaction is a received byte or a connection event, and each
// produces exactly one result transaction carrying the running status, the
// failure reason, the server's result code and two flags: decided
// marks the transaction that ended the working status, send_bind marks a
// connected event seen while still working. The block sustains one
// transaction per clock cycle without back-pressure: the whole parse step
// (a phase transition, an 8-bit shift into the length accumulator and the
// length compares) sits between the input port and the result register; a
// result meeting a stalled result register waits in the skid entry, which
// keeps input ready registered, so ready only drops when both output entries
// are full. Once a verdict is reached every further transaction repeats it.
// ----------------------------------------------------------------------------
module ldap_bind_response_checker_top #(
  parameter int unsigned LengthWidth = lbrc_pkg::LENGTH_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lbrc_in_if.sink           in_i,
  lbrc_out_if.source        out_o
);
  import lbrc_pkg::*;

  logic    in_accept;
  logic    push_ready;
  item_t   item;
  result_t step_result;
  result_t out_data;

  // An input transaction is taken whenever the skid entry is free.
  assign in_i.ready = push_ready;
  assign in_accept  = in_i.valid && push_ready;

  assign item.req_type  = in_i.req_type;
  assign item.data_byte = in_i.data_byte;

  // Parse state is updated only on accepted transactions.
  lbrc_parser #(
    .LengthWidth (LengthWidth)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (item),
    .result_o (step_result)
  );

  lbrc_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_accept),
    .push_data_i  (step_result),
    .push_ready_o (push_ready),
    .out_valid_o  (out_o.valid),
    .out_data_o   (out_data),
    .out_ready_i  (out_o.ready)
  );

  assign out_o.status        = out_data.status;
  assign out_o.fail_reason   = out_data.fail_reason;
  assign out_o.server_result = out_data.server_result;
  assign out_o.decided       = out_data.decided;
  assign out_o.send_bind     = out_data.send_bind;

endmodule
